// ===== design/assert_macros.svh =====
// assertion helpers shared by the tracker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that holds whenever the block is out of reset
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// an implication that holds whenever the block is out of reset
`define CHECK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/tot_pkg.sv =====
// ----------------------------------------------------------------------------
// tot_pkg
// Opcodes, result kinds and sequencer states of the operation tracker.
// ----------------------------------------------------------------------------
package tot_pkg;

   typedef enum logic [3:0] {
      OP_RESERVE       = 4'd0,
      OP_SUBMIT        = 4'd1,
      OP_IS_CURRENT    = 4'd2,
      OP_FINISH        = 4'd3,
      OP_CANCEL_KEY    = 4'd4,
      OP_CANCEL_HANDLE = 4'd5,
      OP_CANCEL_ALL    = 4'd6,
      OP_SHUTDOWN      = 4'd7,
      OP_DISPATCH      = 4'd8
   } opcode_type;

   localparam logic [1:0] KIND_RESPONSE = 2'd0;
   localparam logic [1:0] KIND_NOTICE   = 2'd1;
   localparam logic [1:0] KIND_DISPATCH = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_COMPACT = 6'b001000,
      ST_FLUSH  = 6'b010000,
      ST_HEAD   = 6'b100000
   } state_type;

endpackage

// ===== design/tot_queue.sv =====
// ----------------------------------------------------------------------------
// tot_queue
// Submission order queue: push at the tail, pop at the head, and a compaction
// pass dropping a given slot index, one entry per cycle if no push/pop/clear.
// ----------------------------------------------------------------------------
module tot_queue #(
   parameter int DEPTH = 16,
   parameter int IW = 4,
   parameter int CW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [IW-1:0] push_idx,
   input  logic          pop,
   input  logic          clear,
   input  logic          compact_start,
   input  logic [IW-1:0] compact_idx,
   output logic          compact_busy,
   output logic [IW-1:0] head_idx,
   output logic [CW-1:0] count
);
   logic [IW-1:0] q_ff [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ff, wr_ff;
   logic          cbusy_ff;
   logic [IW-1:0] cidx_ff;

   assign count = count_ff;
   assign head_idx = q_ff[0];
   assign compact_busy = cbusy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cbusy_ff <= 1'b0;
         rd_ff <= '0;
         wr_ff <= '0;
      end else begin
         if (clear) begin
            count_ff <= '0;
         end else if (push) begin
            q_ff[count_ff[IW-1:0]] <= push_idx;
            count_ff <= count_ff + CW'(1);
         end else if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) q_ff[i] <= q_ff[i+1];
            count_ff <= count_ff - CW'(1);
         end else if (compact_start) begin
            cbusy_ff <= 1'b1;
            cidx_ff <= compact_idx;
            rd_ff <= '0;
            wr_ff <= '0;
         end else if (cbusy_ff) begin
            // one queue entry examined per cycle
            if (rd_ff >= count_ff) begin
               cbusy_ff <= 1'b0;
               count_ff <= wr_ff;
            end else begin
               if (q_ff[rd_ff[IW-1:0]] != cidx_ff) begin
                  q_ff[wr_ff[IW-1:0]] <= q_ff[rd_ff[IW-1:0]];
                  wr_ff <= wr_ff + CW'(1);
               end
               rd_ff <= rd_ff + CW'(1);
            end
         end
      end
   end
   assign count_in = count_ff;

   `include "assert_macros.svh"
   `CHECK_ALWAYS(a_count_bound, clock, reset, count_in <= CW'(DEPTH), "queue count over depth")
   `CHECK_IMPL(a_wr_le_rd, clock, reset, cbusy_ff, wr_ff <= rd_ff, "compaction write passed read")
   `CHECK_IMPL(a_no_push_busy, clock, reset, cbusy_ff, !push && !pop, "queue touched mid compaction")
endmodule

// ===== design/tagged_operation_tracker.sv =====
// ----------------------------------------------------------------------------
// tagged_operation_tracker
// Table of pending operations with generation tags and an ordered queue.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each result sits on
// the rsp_ ports for one cycle under rsp_valid, and the receiver cannot stall
// it. The table is searched by one shared key comparator, one slot per cycle,
// so a keyed request registers its response once every slot has been read;
// a removal first runs a queue compaction and answers when it is done.
// Cancel-all and shutdown walk every slot, give one notice per live slot and
// then a final response. Dispatch pops the queue head and answers from ST_HEAD
// once that slot is read. An unknown opcode, a repeated shutdown and a
// dispatch on an empty queue answer at once and leave busy low. After a
// successful submit or a flush busy stays high while the queue takes the
// update.
module tagged_operation_tracker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_handle_generation,
   input  logic        req_payload_present,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic        rsp_ok,
   output logic [31:0] rsp_out_key,
   output logic [31:0] rsp_out_generation,
   output logic        rsp_last
);
   import tot_pkg::*;
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1) + 1;

   logic [TABLE_DEPTH-1:0] valid_ff, subm_ff;
   logic [31:0] key_mem [TABLE_DEPTH];
   logic [31:0] gen_mem [TABLE_DEPTH];
   logic [31:0] rd_key_ff, rd_gen_ff;
   logic [31:0] gcnt_ff;
   logic        stop_ff;
   state_type   state_ff;
   logic [3:0]  op_ff;
   logic [31:0] k_ff, g_ff;
   logic        pay_ff;
   logic [IW:0] ptr_ff;
   logic        found_ff, hasfree_ff;
   logic [IW-1:0] fslot_ff, free_ff;
   logic [31:0] fgen_ff;
   logic        rdv_ff;
   logic [IW-1:0] rdi_ff;
   logic [IW-1:0] rd_addr;

   logic        q_push, q_pop, q_clear, q_cstart, q_cbusy;
   logic [IW-1:0] q_head;
   logic [CW-1:0] q_count;

   tot_queue #(.DEPTH(TABLE_DEPTH), .IW(IW), .CW(CW)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_idx(fslot_ff),
      .pop(q_pop), .clear(q_clear), .compact_start(q_cstart),
      .compact_idx(fslot_ff), .compact_busy(q_cbusy), .head_idx(q_head),
      .count(q_count));

   logic [31:0] gnext;
   assign gnext = (gcnt_ff + 32'd1 == 32'd0) ? 32'd1 : gcnt_ff + 32'd1;
   // a pending queue push or clear still holds off the next request
   assign busy = (state_ff != ST_IDLE) || q_push || q_clear;

   // walks follow the slot pointer, other reads use the captured index
   assign rd_addr = (state_ff == ST_SCAN || state_ff == ST_FLUSH) ? ptr_ff[IW-1:0] : rdi_ff;

   logic gen_match;
   assign gen_match = found_ff && (fgen_ff == g_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         subm_ff <= '0;
         gcnt_ff <= '0;
         stop_ff <= 1'b0;
         rsp_valid <= 1'b0;
         q_push <= 1'b0;
         q_pop <= 1'b0;
         q_clear <= 1'b0;
         q_cstart <= 1'b0;
         rdv_ff <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         q_push <= 1'b0;
         q_pop <= 1'b0;
         q_clear <= 1'b0;
         q_cstart <= 1'b0;
         rdv_ff <= 1'b0;
         // shared read port: one slot read per cycle, the read data is registered
         rd_key_ff <= key_mem[rd_addr];
         rd_gen_ff <= gen_mem[rd_addr];
         unique case (state_ff)
            ST_IDLE: begin
               if (start && !busy) begin
                  op_ff <= req_opcode;
                  k_ff <= req_key;
                  g_ff <= req_handle_generation;
                  pay_ff <= req_payload_present;
                  ptr_ff <= '0;
                  found_ff <= 1'b0;
                  hasfree_ff <= 1'b0;
                  unique case (req_opcode)
                     OP_CANCEL_ALL: state_ff <= ST_FLUSH;
                     OP_SHUTDOWN: begin
                        if (stop_ff) begin
                           rsp_valid <= 1'b1;
                           rsp_kind <= KIND_RESPONSE;
                           rsp_ok <= 1'b0;
                           rsp_out_key <= '0;
                           rsp_out_generation <= '0;
                           rsp_last <= 1'b1;
                        end else begin
                           stop_ff <= 1'b1;
                           state_ff <= ST_FLUSH;
                        end
                     end
                     OP_DISPATCH: begin
                        if (q_count == '0) begin
                           rsp_valid <= 1'b1;
                           rsp_kind <= KIND_DISPATCH;
                           rsp_ok <= 1'b0;
                           rsp_out_key <= '0;
                           rsp_out_generation <= '0;
                           rsp_last <= 1'b1;
                        end else begin
                           fslot_ff <= q_head;
                           rdi_ff <= q_head;
                           q_pop <= 1'b1;
                           state_ff <= ST_HEAD;
                        end
                     end
                     OP_RESERVE, OP_SUBMIT, OP_IS_CURRENT, OP_FINISH,
                     OP_CANCEL_KEY, OP_CANCEL_HANDLE: state_ff <= ST_SCAN;
                     default: begin
                        rsp_valid <= 1'b1;
                        rsp_kind <= KIND_RESPONSE;
                        rsp_ok <= 1'b0;
                        rsp_out_key <= '0;
                        rsp_out_generation <= '0;
                        rsp_last <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // issue a read for ptr, compare the one issued last cycle
               if (ptr_ff < (IW+1)'(TABLE_DEPTH)) begin
                  rdi_ff <= ptr_ff[IW-1:0];
                  rdv_ff <= valid_ff[ptr_ff[IW-1:0]];
                  if (!valid_ff[ptr_ff[IW-1:0]] && !hasfree_ff) begin
                     hasfree_ff <= 1'b1;
                     free_ff <= ptr_ff[IW-1:0];
                  end
                  ptr_ff <= ptr_ff + 1'b1;
               end else begin
                  state_ff <= ST_DECIDE;
               end
               if (rdv_ff && !found_ff && rd_key_ff == k_ff) begin
                  found_ff <= 1'b1;
                  fslot_ff <= rdi_ff;
                  fgen_ff <= rd_gen_ff;
               end
            end
            ST_DECIDE: begin
               rsp_valid <= 1'b1;
               rsp_kind <= KIND_RESPONSE;
               rsp_out_key <= k_ff;
               rsp_out_generation <= g_ff;
               rsp_last <= 1'b1;
               rsp_ok <= 1'b0;
               state_ff <= ST_IDLE;
               unique case (op_ff)
                  OP_RESERVE: begin
                     if (k_ff != '0 && pay_ff && !stop_ff && !found_ff && hasfree_ff) begin
                        gcnt_ff <= gnext;
                        valid_ff[free_ff] <= 1'b1;
                        subm_ff[free_ff] <= 1'b0;
                        key_mem[free_ff] <= k_ff;
                        gen_mem[free_ff] <= gnext;
                        rsp_ok <= 1'b1;
                        rsp_out_generation <= gnext;
                     end else begin
                        rsp_out_generation <= '0;
                     end
                  end
                  OP_SUBMIT: begin
                     if (k_ff != '0 && g_ff != '0 && pay_ff && !stop_ff && gen_match
                         && !subm_ff[fslot_ff] && q_count < CW'(TABLE_DEPTH)) begin
                        subm_ff[fslot_ff] <= 1'b1;
                        q_push <= 1'b1;
                        rsp_ok <= 1'b1;
                     end
                  end
                  OP_IS_CURRENT: rsp_ok <= gen_match;
                  OP_FINISH, OP_CANCEL_HANDLE: begin
                     if (gen_match) begin
                        valid_ff[fslot_ff] <= 1'b0;
                        subm_ff[fslot_ff] <= 1'b0;
                        q_cstart <= 1'b1;
                        rsp_valid <= (op_ff == OP_CANCEL_HANDLE);
                        rsp_kind <= KIND_NOTICE;
                        rsp_ok <= 1'b1;
                        rsp_last <= 1'b0;
                        state_ff <= ST_COMPACT;
                     end
                  end
                  OP_CANCEL_KEY: begin
                     if (found_ff) begin
                        g_ff <= fgen_ff;
                        valid_ff[fslot_ff] <= 1'b0;
                        subm_ff[fslot_ff] <= 1'b0;
                        q_cstart <= 1'b1;
                        rsp_kind <= KIND_NOTICE;
                        rsp_ok <= 1'b1;
                        rsp_last <= 1'b0;
                        rsp_out_generation <= fgen_ff;
                        state_ff <= ST_COMPACT;
                     end else begin
                        rsp_out_generation <= '0;
                     end
                  end
                  default: ;
               endcase
            end
            ST_COMPACT: begin
               if (!q_cstart && !q_cbusy) begin
                  rsp_valid <= 1'b1;
                  rsp_kind <= KIND_RESPONSE;
                  rsp_ok <= 1'b1;
                  rsp_out_key <= k_ff;
                  rsp_out_generation <= g_ff;
                  rsp_last <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_FLUSH: begin
               // one slot per cycle; read issued at ptr, notice from the previous
               if (rdv_ff) begin
                  rsp_valid <= 1'b1;
                  rsp_kind <= KIND_NOTICE;
                  rsp_ok <= 1'b1;
                  rsp_out_key <= rd_key_ff;
                  rsp_out_generation <= rd_gen_ff;
                  rsp_last <= 1'b0;
               end
               if (ptr_ff < (IW+1)'(TABLE_DEPTH)) begin
                  rdi_ff <= ptr_ff[IW-1:0];
                  rdv_ff <= valid_ff[ptr_ff[IW-1:0]];
                  ptr_ff <= ptr_ff + 1'b1;
               end else if (!rdv_ff) begin
                  valid_ff <= '0;
                  subm_ff <= '0;
                  q_clear <= 1'b1;
                  rsp_valid <= 1'b1;
                  rsp_kind <= KIND_RESPONSE;
                  rsp_ok <= 1'b1;
                  rsp_out_key <= '0;
                  rsp_out_generation <= '0;
                  rsp_last <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_HEAD: begin
               rdv_ff <= 1'b1;
               if (rdv_ff) begin
                  rsp_valid <= 1'b1;
                  rsp_kind <= KIND_DISPATCH;
                  rsp_ok <= valid_ff[fslot_ff];
                  rsp_out_key <= valid_ff[fslot_ff] ? rd_key_ff : '0;
                  rsp_out_generation <= valid_ff[fslot_ff] ? rd_gen_ff : '0;
                  rsp_last <= 1'b1;
                  rdv_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `include "assert_macros.svh"
   `CHECK_ALWAYS(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `CHECK_IMPL(a_last_idle, clock, reset, rsp_valid && rsp_last, state_ff == ST_IDLE, "last result while still busy")
   `CHECK_IMPL(a_idle_quiet, clock, reset, state_ff == ST_IDLE && !$past(busy), !rsp_valid || $past(start), "result without a request")
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tagged_operation_tracker with a table of directed requests, then
// random request streams biased toward live keys and generations. Results
// are checked against a typed row or an in-bench model of table, queue, tags.
// ----------------------------------------------------------------------------
module testbench;
   import tot_pkg::*;

   localparam int DEPTH = 16;
   localparam logic [3:0] OP_UNUSED = 4'd15;
   localparam logic [3:0] OP_FIRST_BAD = 4'd9;

   typedef struct {
      logic [1:0]  kind;
      logic        ok;
      logic [31:0] key;
      logic [31:0] gen;
      logic        last;
   } outcome_type;

   typedef struct {
      logic [3:0]  op;
      logic [31:0] key;
      logic [31:0] hgen;
      logic        pay;
      bit          typed;
      logic [1:0]  kind;
      logic        ok;
      logic [31:0] k;
      logic [31:0] g;
   } row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_opcode;
   logic [31:0] req_key;
   logic [31:0] req_handle_generation;
   logic        req_payload_present;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic        rsp_ok;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_generation;
   logic        rsp_last;

   outcome_type pending_results[$];
   int       mismatches = 0;

   // model of the table
   bit          live[DEPTH];
   logic [31:0] live_key[DEPTH];
   logic [31:0] live_gen[DEPTH];
   bit          queued[DEPTH];
   int          run_order[$];
   logic [31:0] tag_counter;
   bit          stopping;

   tagged_operation_tracker #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_key(req_key),
      .req_handle_generation(req_handle_generation),
      .req_payload_present(req_payload_present),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_ok(rsp_ok),
      .rsp_out_key(rsp_out_key), .rsp_out_generation(rsp_out_generation),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("** tagged_operation_tracker: FAILED **");
      $finish;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic void expect_result(logic [1:0] kind, logic ok, logic [31:0] k,
                                         logic [31:0] g, logic last);
      outcome_type r;
      r.kind = kind; r.ok = ok; r.key = k; r.gen = g; r.last = last;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic int find_slot(logic [31:0] k);
      for (int i = 0; i < DEPTH; i++)
         if (live[i] && live_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int s);
      live[s] = 0;
      queued[s] = 0;
      for (int i = run_order.size() - 1; i >= 0; i--)
         if (run_order[i] == s) run_order.delete(i);
   endfunction

   function automatic void flush_table();
      for (int i = 0; i < DEPTH; i++)
         if (live[i]) begin
            expect_result(KIND_NOTICE, 1, live_key[i], live_gen[i], 0);
            live[i] = 0;
            queued[i] = 0;
         end
      run_order.delete();
   endfunction

   function automatic void predict_request(logic [3:0] op, logic [31:0] k,
                                           logic [31:0] g, logic pay);
      int s;
      int free_slot;
      logic [31:0] eg;
      s = find_slot(k);
      free_slot = -1;
      case (op)
         OP_RESERVE: begin
            if (k != 0 && pay && !stopping && s < 0)
               for (int i = DEPTH - 1; i >= 0; i--)
                  if (!live[i]) free_slot = i;
            if (free_slot < 0) expect_result(KIND_RESPONSE, 0, k, 0, 1);
            else begin
               tag_counter = tag_counter + 1;
               if (tag_counter == 0) tag_counter = 1;
               live[free_slot] = 1;
               live_key[free_slot] = k;
               live_gen[free_slot] = tag_counter;
               queued[free_slot] = 0;
               expect_result(KIND_RESPONSE, 1, k, tag_counter, 1);
            end
         end
         OP_SUBMIT: begin
            if (k != 0 && g != 0 && pay && !stopping && s >= 0 && !queued[s]
                && live_gen[s] == g && run_order.size() < DEPTH) begin
               run_order.insert(run_order.size(), s);
               queued[s] = 1;
               expect_result(KIND_RESPONSE, 1, k, g, 1);
            end else expect_result(KIND_RESPONSE, 0, k, g, 1);
         end
         OP_IS_CURRENT: expect_result(KIND_RESPONSE, s >= 0 && live_gen[s] == g, k, g, 1);
         OP_FINISH, OP_CANCEL_HANDLE: begin
            if (s >= 0 && live_gen[s] == g) begin
               drop_slot(s);
               if (op == OP_CANCEL_HANDLE) expect_result(KIND_NOTICE, 1, k, g, 0);
               expect_result(KIND_RESPONSE, 1, k, g, 1);
            end else expect_result(KIND_RESPONSE, 0, k, g, 1);
         end
         OP_CANCEL_KEY: begin
            if (s >= 0) begin
               eg = live_gen[s];
               drop_slot(s);
               expect_result(KIND_NOTICE, 1, k, eg, 0);
               expect_result(KIND_RESPONSE, 1, k, eg, 1);
            end else expect_result(KIND_RESPONSE, 0, k, 0, 1);
         end
         OP_CANCEL_ALL: begin
            flush_table();
            expect_result(KIND_RESPONSE, 1, 0, 0, 1);
         end
         OP_SHUTDOWN: begin
            if (stopping) expect_result(KIND_RESPONSE, 0, 0, 0, 1);
            else begin
               stopping = 1;
               flush_table();
               expect_result(KIND_RESPONSE, 1, 0, 0, 1);
            end
         end
         OP_DISPATCH: begin
            if (run_order.size() == 0) expect_result(KIND_DISPATCH, 0, 0, 0, 1);
            else begin
               s = run_order[0];
               run_order.delete(0);
               if (live[s]) expect_result(KIND_DISPATCH, 1, live_key[s], live_gen[s], 1);
               else expect_result(KIND_DISPATCH, 0, 0, 0, 1);
            end
         end
         default: expect_result(KIND_RESPONSE, 0, 0, 0, 1);
      endcase
   endfunction

   // start is left high after acceptance so back-to-back requests need no toggle
   task automatic send_request(input row_type r, input int gap);
      int before_count;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_opcode <= r.op;
      req_key <= r.key;
      req_handle_generation <= r.hgen;
      req_payload_present <= r.pay;
      do @(posedge clock); while (busy);
      before_count = pending_results.size();
      predict_request(r.op, r.key, r.hgen, r.pay);
      if (r.typed) begin
         while (pending_results.size() > before_count) void'(pending_results.pop_back());
         expect_result(r.kind, r.ok, r.k, r.g, 1);
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) report("result with nothing pending");
         else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (rsp_kind !== want.kind)
               report($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_ok !== want.ok)
               report($sformatf("ok %0d, want %0d", rsp_ok, want.ok));
            if (rsp_out_key !== want.key)
               report($sformatf("key %h, want %h", rsp_out_key, want.key));
            if (rsp_out_generation !== want.gen)
               report($sformatf("generation %h, want %h", rsp_out_generation, want.gen));
            if (rsp_last !== want.last)
               report($sformatf("last %0d, want %0d", rsp_last, want.last));
         end
      end
   end

   function automatic row_type plain(logic [3:0] op, logic [31:0] k, logic [31:0] g, logic pay);
      row_type r;
      r = '{op, k, g, pay, 0, KIND_RESPONSE, 0, 0, 0};
      return r;
   endfunction

   function automatic row_type random_request();
      row_type r;
      int pick;
      int s;
      pick = $urandom_range(0, 99);
      if (pick < 30) r.op = OP_RESERVE;
      else if (pick < 50) r.op = OP_SUBMIT;
      else if (pick < 62) r.op = OP_DISPATCH;
      else if (pick < 72) r.op = OP_FINISH;
      else if (pick < 80) r.op = OP_CANCEL_KEY;
      else if (pick < 88) r.op = OP_CANCEL_HANDLE;
      else if (pick < 95) r.op = OP_IS_CURRENT;
      else if (pick < 97) r.op = OP_CANCEL_ALL;
      else r.op = 4'($urandom_range(OP_FIRST_BAD, OP_UNUSED));
      pick = $urandom_range(0, 99);
      if (pick < 3) r.key = 0;
      else if (pick < 13) r.key = $urandom;
      else r.key = $urandom_range(1, 24);
      r.hgen = $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) r.hgen = $urandom;
      // mostly aim at a live entry so the keyed paths succeed
      s = $urandom_range(0, DEPTH - 1);
      if (r.op != OP_RESERVE && live[s] && $urandom_range(0, 9) < 7) begin
         r.key = live_key[s];
         if ($urandom_range(0, 9) < 8) r.hgen = live_gen[s];
      end
      r.pay = $urandom_range(0, 15) != 0;
      r.typed = 0;
      return r;
   endfunction

   initial begin
      row_type directed[] = '{
         '{OP_DISPATCH, 0, 0, 1, 1, KIND_DISPATCH, 0, 0, 0},
         '{OP_RESERVE, 0, 0, 1, 1, KIND_RESPONSE, 0, 0, 0},
         '{OP_RESERVE, 32'hFFFF_FFFF, 0, 0, 1, KIND_RESPONSE, 0, 32'hFFFF_FFFF, 0},
         '{OP_RESERVE, 32'hFFFF_FFFF, 0, 1, 1, KIND_RESPONSE, 1, 32'hFFFF_FFFF, 1},
         '{OP_RESERVE, 1, 32'hFFFF_FFFF, 1, 1, KIND_RESPONSE, 1, 1, 2},
         '{OP_RESERVE, 32'hFFFF_FFFF, 0, 1, 1, KIND_RESPONSE, 0, 32'hFFFF_FFFF, 0},
         '{OP_SUBMIT, 32'hFFFF_FFFF, 1, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_SUBMIT, 32'hFFFF_FFFF, 1, 1, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_SUBMIT, 32'hFFFF_FFFF, 1, 1, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_SUBMIT, 1, 0, 1, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_SUBMIT, 1, 5, 1, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_SUBMIT, 1, 2, 1, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_IS_CURRENT, 32'hFFFF_FFFF, 1, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_IS_CURRENT, 1, 3, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_DISPATCH, 0, 0, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_FINISH, 1, 2, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_DISPATCH, 0, 0, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_CANCEL_HANDLE, 32'hFFFF_FFFF, 1, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_CANCEL_KEY, 7, 0, 0, 1, KIND_RESPONSE, 0, 7, 0},
         '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, KIND_RESPONSE, 0, 0, 0},
         '{OP_RESERVE, 3, 0, 1, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_RESERVE, 4, 0, 1, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_CANCEL_KEY, 3, 0, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_CANCEL_ALL, 0, 0, 0, 0, KIND_RESPONSE, 0, 0, 0}
      };
      row_type closing[] = '{
         '{OP_SHUTDOWN, 0, 0, 0, 0, KIND_RESPONSE, 0, 0, 0},
         '{OP_SHUTDOWN, 0, 0, 0, 1, KIND_RESPONSE, 0, 0, 0},
         '{OP_RESERVE, 10, 0, 1, 1, KIND_RESPONSE, 0, 10, 0},
         '{OP_DISPATCH, 0, 0, 0, 1, KIND_DISPATCH, 0, 0, 0}
      };
      int gap;
      int waited;

      reset = 1;
      start = 0;
      req_opcode = OP_RESERVE;
      req_key = 0;
      req_handle_generation = 0;
      req_payload_present = 0;
      tag_counter = 0;
      stopping = 0;
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = 0;
         queued[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 0;

      foreach (directed[i]) send_request(directed[i], $urandom_range(0, 3));

      for (int n = 0; n < 105; n++) begin
         // long runs with no gaps, otherwise a random gap before each request
         gap = (n % 40 < 12) ? 0 : $urandom_range(0, 14);
         if (n == 60 || n == 100) begin
            start <= 0;
            while (pending_results.size() != 0) @(posedge clock);
            gap = 0;
         end
         // fill the table in one stretch so the full case is reached
         if (n >= 70 && n < 90) send_request(plain(OP_RESERVE, 100 + n, 0, 1), gap);
         else send_request(random_request(), gap);
      end

      foreach (closing[i]) send_request(closing[i], $urandom_range(0, 14));
      start <= 0;

      waited = 0;
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("** tagged_operation_tracker: PASSED **");
      else begin
         if (pending_results.size() != 0) report("expected results never arrived");
         $display("** tagged_operation_tracker: FAILED **");
      end
      $finish;
   end

endmodule
